@@ rtl/core/fwfa_pkg.sv @@
// shared types and constants for the segment allocator
`default_nettype none
package fwfa_pkg;
	localparam int MAX_SEGMENTS = 64;
	localparam int IDX_W = $clog2(MAX_SEGMENTS);
	localparam int CNT_W = IDX_W + 1;
	localparam logic [16:0] REGION_MAX_BYTES = 17'd65536;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_FIT    = 3'd1;
	localparam logic [2:0] ST_NONE      = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_ZERO      = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND = 3'd5;

	localparam logic [1:0] STRAT_FIRST = 2'd1;
	localparam logic [1:0] STRAT_WORST = 2'd2;

	localparam logic [1:0] REG_STRATEGY = 2'd0;
	localparam logic [1:0] REG_BLOCK    = 2'd1;
	localparam logic [1:0] REG_REGION   = 2'd2;

	// classified command handed from front to back
	typedef struct packed {
		logic        is_free;
		logic        reject;
		logic [2:0]  rej_status;
		logic [16:0] need;
		logic [15:0] off;
	} cmd_t;

	// one entry of the segment table
	typedef struct packed {
		logic        used;
		logic [16:0] len;
		logic [16:0] start;
	} seg_t;
endpackage
`default_nettype wire

@@ rtl/core/fwfa_front.sv @@
// front part: accepts items, rounds requests and screens early rejects
`default_nettype none
module fwfa_front import fwfa_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        op,
	input  wire logic [16:0] request_bytes,
	input  wire logic [15:0] release_offset,
	input  wire logic [1:0]  strategy,
	input  wire logic [12:0] block_bytes,
	input  wire logic        q_full,
	input  wire logic        q_empty,
	input  wire logic        back_busy,
	output logic             busy,
	output logic             push,
	output cmd_t             cmd
);
	// remainder found by restoring shift-and-subtract, one request bit a cycle
	localparam logic [1:0] F_IDLE  = 2'd0;
	localparam logic [1:0] F_DIV   = 2'd1;
	localparam logic [1:0] F_ROUND = 2'd2;
	localparam logic [1:0] F_PUSH  = 2'd3;
	logic [1:0]  state_q;
	logic [16:0] rem_q;
	logic [16:0] div_q;
	logic [4:0]  cnt_q;
	logic [16:0] trial;
	logic [16:0] blk;
	cmd_t        cmd_q;

	assign blk = (block_bytes == 13'd0) ? 17'd1 : {4'd0, block_bytes};
	assign trial = {rem_q[15:0], div_q[16]};
	assign busy = (state_q != F_IDLE) || !q_empty || back_busy || q_full;
	assign push = (state_q == F_PUSH);
	assign cmd = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: if (start && !busy) begin
					cmd_q.is_free <= op;
					cmd_q.off     <= release_offset;
					cmd_q.need    <= request_bytes;
					div_q         <= request_bytes;
					rem_q         <= 17'd0;
					cnt_q         <= 5'd16;
					if (!op && strategy != STRAT_FIRST && strategy != STRAT_WORST) begin
						cmd_q.reject <= 1'b1; cmd_q.rej_status <= ST_NONE;
						state_q <= F_PUSH;
					end else if (!op && request_bytes == 17'd0) begin
						cmd_q.reject <= 1'b1; cmd_q.rej_status <= ST_ZERO;
						state_q <= F_PUSH;
					end else begin
						cmd_q.reject <= 1'b0; cmd_q.rej_status <= ST_OK;
						state_q <= op ? F_PUSH : F_DIV;
					end
				end
				F_DIV: begin
					rem_q <= (trial >= blk) ? trial - blk : trial;
					div_q <= {div_q[15:0], 1'b0};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) state_q <= F_ROUND;
				end
				F_ROUND: begin
					// round up; a need past the region just fails to fit
					if (rem_q != 17'd0) begin
						if ({1'b0, cmd_q.need} + {1'b0, blk - rem_q} > 18'h1ffff)
							cmd_q.need <= 17'h1ffff;
						else
							cmd_q.need <= cmd_q.need + (blk - rem_q);
					end
					state_q <= F_PUSH;
				end
				F_PUSH: state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/fwfa_queue.sv @@
// two-entry command queue between front and back
`default_nettype none
module fwfa_queue import fwfa_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      din,
	input  wire logic pop,
	output cmd_t      dout,
	output logic      empty,
	output logic      full
);
	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (pop && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/fwfa_back.sv @@
// back part: walks and edits the segment table
`default_nettype none
module fwfa_back import fwfa_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        init,
	input  wire logic [16:0] region_len,
	input  wire logic [1:0]  strategy,
	input  wire logic        q_empty,
	input  cmd_t             cmd,
	output logic             pop,
	output logic             active,
	output logic             done,
	output logic [15:0]      granted_offset,
	output logic [2:0]       status
);
	localparam logic [2:0] B_INIT  = 3'd0;
	localparam logic [2:0] B_IDLE  = 3'd1;
	localparam logic [2:0] B_SCAN  = 3'd2;
	localparam logic [2:0] B_COMP  = 3'd3;
	localparam logic [2:0] B_SHIFT = 3'd4;
	localparam logic [2:0] B_MERGE = 3'd5;
	localparam logic [2:0] B_MEND  = 3'd6;
	localparam logic [2:0] B_DONE  = 3'd7;

	// segment table in memory, one registered read and one write a cycle;
	// entries at or above count_q are never used, so init writes entry 0 only
	seg_t             seg_mem [MAX_SEGMENTS];
	seg_t             rd_q;
	logic [IDX_W-1:0] rd_addr;
	logic             we;
	logic [IDX_W-1:0] wr_addr;
	seg_t             wr_data;

	logic [CNT_W-1:0] count_q;
	logic [16:0]      region_len_q;
	logic [2:0]       state_q;
	cmd_t             c_q;
	logic [CNT_W-1:0] i_q;
	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] dst_s1;
	logic [IDX_W-1:0] pick_q;
	logic [16:0]      pick_start_q;
	logic             found_q;
	logic [16:0]      best_q;
	logic [CNT_W-1:0] w_q;
	logic [IDX_W-1:0] wp_q;
	seg_t             hold_q;
	logic             hold_v_q;
	logic [IDX_W-1:0] ix;
	logic [IDX_W-1:0] wx;
	logic             last_s1;
	logic             scan_hit;
	logic             split;
	logic             table_full;
	seg_t             mg;
	logic             mg_join;

	assign ix = i_q[IDX_W-1:0];
	assign wx = w_q[IDX_W-1:0];
	assign active = (state_q != B_IDLE);
	assign pop = (state_q == B_IDLE) && !q_empty;
	assign last_s1 = ({1'b0, idx_s1} == count_q - 1'b1);
	assign split = (best_q != c_q.need);
	assign table_full = (count_q >= CNT_W'(MAX_SEGMENTS));
	assign mg_join = hold_v_q && !hold_q.used && !mg.used;

	// entry under test in the walk
	always_comb begin
		if (c_q.is_free)
			scan_hit = rd_q.used && (rd_q.start == {1'b0, c_q.off});
		else
			scan_hit = !rd_q.used && (rd_q.len >= c_q.need) &&
			           (!found_q || rd_q.len > best_q);
	end

	// the released entry reads as free during compaction
	always_comb begin
		mg = rd_q;
		if (idx_s1 == pick_q) mg.used = 1'b0;
	end

	always_comb begin
		rd_addr = (state_q == B_SHIFT) ? wx - 1'b1 : ix;
	end

	always_comb begin
		we = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		case (state_q)
			B_INIT: begin
				we = 1'b1;
				wr_data.len = region_len_q;
			end
			B_COMP: begin
				// mark the picked entry used before the tail moves up
				if (found_q && (!split || !table_full)) begin
					we = 1'b1;
					wr_addr = pick_q;
					wr_data.used = 1'b1;
					wr_data.len = c_q.need;
					wr_data.start = pick_start_q;
				end
			end
			B_SHIFT: begin
				if (v_s1) begin
					we = 1'b1;
					wr_addr = dst_s1;
					wr_data = rd_q;
				end else if (w_q <= {1'b0, pick_q} + 1'b1) begin
					we = 1'b1;
					wr_addr = pick_q + 1'b1;
					wr_data.len = best_q - c_q.need;
					wr_data.start = pick_start_q + c_q.need;
				end
			end
			B_MERGE: begin
				if (v_s1 && hold_v_q && !mg_join) begin
					we = 1'b1;
					wr_addr = wp_q;
					wr_data = hold_q;
				end
			end
			B_MEND: begin
				we = 1'b1;
				wr_addr = wp_q;
				wr_data = hold_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) seg_mem[wr_addr] <= wr_data;
		rd_q <= seg_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_INIT;
			count_q <= CNT_W'(1);
			region_len_q <= REGION_MAX_BYTES;
			done <= 1'b0;
		end else if (init) begin
			state_q <= B_INIT;
			count_q <= CNT_W'(1);
			region_len_q <= region_len;
			done <= 1'b0;
		end else begin
			done <= (state_q == B_DONE);
			case (state_q)
				B_INIT: state_q <= B_IDLE;
				B_IDLE: if (!q_empty) begin
					c_q <= cmd;
					i_q <= '0;
					v_s1 <= 1'b0;
					found_q <= 1'b0;
					best_q <= '0;
					pick_q <= '0;
					pick_start_q <= '0;
					wp_q <= '0;
					hold_v_q <= 1'b0;
					if (cmd.reject) begin
						status <= cmd.rej_status; granted_offset <= 16'd0;
						state_q <= B_DONE;
					end else begin
						state_q <= B_SCAN;
					end
				end
				B_SCAN: begin
					// reads run one entry ahead of the compare
					if (v_s1 && scan_hit) begin
						found_q <= 1'b1; best_q <= rd_q.len;
						pick_q <= idx_s1; pick_start_q <= rd_q.start;
					end
					if (v_s1 && ((scan_hit && (c_q.is_free || strategy == STRAT_FIRST)) ||
					    last_s1)) begin
						v_s1 <= 1'b0;
						i_q <= '0;
						if (!c_q.is_free) begin
							state_q <= B_COMP;
						end else if (scan_hit) begin
							state_q <= B_MERGE;
						end else begin
							status <= ST_NOT_FOUND; granted_offset <= 16'd0;
							state_q <= B_DONE;
						end
					end else begin
						v_s1 <= (i_q < count_q);
						idx_s1 <= ix;
						i_q <= i_q + 1'b1;
					end
				end
				B_COMP: begin
					if (!found_q) begin
						status <= ST_NO_FIT; granted_offset <= 16'd0;
						state_q <= B_DONE;
					end else if (split) begin
						if (table_full) begin
							status <= ST_FULL; granted_offset <= 16'd0;
							state_q <= B_DONE;
						end else begin
							w_q <= count_q;
							v_s1 <= 1'b0;
							state_q <= B_SHIFT;
						end
					end else begin
						status <= ST_OK; granted_offset <= pick_start_q[15:0];
						state_q <= B_DONE;
					end
				end
				B_SHIFT: begin
					// tail moves up one entry a cycle, then the remainder goes in
					if (w_q > {1'b0, pick_q} + 1'b1) begin
						v_s1 <= 1'b1;
						dst_s1 <= wx;
						w_q <= w_q - 1'b1;
					end else begin
						v_s1 <= 1'b0;
						if (!v_s1) begin
							count_q <= count_q + 1'b1;
							status <= ST_OK;
							granted_offset <= pick_start_q[15:0];
							state_q <= B_DONE;
						end
					end
				end
				B_MERGE: begin
					// compaction pass: runs of free entries fold into one
					if (v_s1) begin
						if (!hold_v_q) begin
							hold_q <= mg;
							hold_v_q <= 1'b1;
						end else if (mg_join) begin
							hold_q.len <= hold_q.len + mg.len;
						end else begin
							wp_q <= wp_q + 1'b1;
							hold_q <= mg;
						end
					end
					if (v_s1 && last_s1) begin
						v_s1 <= 1'b0;
						state_q <= B_MEND;
					end else begin
						v_s1 <= (i_q < count_q);
						idx_s1 <= ix;
						i_q <= i_q + 1'b1;
					end
				end
				B_MEND: begin
					count_q <= {1'b0, wp_q} + 1'b1;
					status <= ST_OK; granted_offset <= 16'd0;
					state_q <= B_DONE;
				end
				B_DONE: state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/first_worst_fit_allocator.sv @@
// top level of the segment allocator
// A transaction is accepted when start is high and busy is low; busy stays high
// until its single result has been shown, so one item is in flight at a time.
// The result (granted_offset, status) is valid for exactly one cycle while done
// is high; the receiver cannot stall it. An allocate finds request_bytes modulo
// block_bytes by shift-and-subtract, then rounds up and hands over; the back
// then walks the table at one entry a cycle (up to 64 entries, worst fit always
// walks all of it) and a split moves the tail up one entry a cycle (up to 62
// entries). A free walks the table to find its segment, then rewrites the table
// in one compaction pass at one entry a cycle. Busy falls the cycle after done.
// Writing any configuration register reinitialises the table to one free segment.
`default_nettype none
module first_worst_fit_allocator import fwfa_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        op,
	input  wire logic [16:0] request_bytes,
	input  wire logic [15:0] release_offset,
	output logic             done,
	output logic [15:0]      granted_offset,
	output logic [2:0]       status,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic [1:0]  strategy_q;
	logic [12:0] block_q;
	logic [16:0] region_q;
	logic        wr, hit, push, pop, q_empty, q_full, back_active;
	logic [16:0] region_len;
	cmd_t        f_cmd, q_cmd;

	assign pready = 1'b1;
	assign wr  = psel && penable && pwrite;
	assign hit = wr && (paddr[3:2] <= REG_REGION);

	// clamp the region size as the table is built
	always_comb begin
		region_len = pwdata[16:0];
		if (region_len == 17'd0) region_len = 17'd1;
		if (region_len > REGION_MAX_BYTES) region_len = REGION_MAX_BYTES;
		if (paddr[3:2] != REG_REGION) begin
			region_len = region_q;
			if (region_len == 17'd0) region_len = 17'd1;
			if (region_len > REGION_MAX_BYTES) region_len = REGION_MAX_BYTES;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q <= 2'd0;
			block_q    <= 13'd1;
			region_q   <= 17'd65536;
		end else if (hit) begin
			case (paddr[3:2])
				REG_STRATEGY: strategy_q <= pwdata[1:0];
				REG_BLOCK:    block_q    <= pwdata[12:0];
				REG_REGION:   region_q   <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_STRATEGY: prdata = {30'd0, strategy_q};
			REG_BLOCK:    prdata = {19'd0, block_q};
			REG_REGION:   prdata = {15'd0, region_q};
			default:      prdata = 32'd0;
		endcase
	end

	fwfa_front u_front (
		.clk, .arst_n, .start, .op, .request_bytes, .release_offset,
		.strategy(strategy_q), .block_bytes(block_q),
		.q_full, .q_empty, .back_busy(back_active || done),
		.busy, .push, .cmd(f_cmd)
	);

	fwfa_queue u_queue (
		.clk, .arst_n, .push, .din(f_cmd), .pop, .dout(q_cmd),
		.empty(q_empty), .full(q_full)
	);

	fwfa_back u_back (
		.clk, .arst_n, .init(hit), .region_len, .strategy(strategy_q),
		.q_empty, .cmd(q_cmd), .pop, .active(back_active), .done,
		.granted_offset, .status
	);
endmodule
`default_nettype wire
